// ===== rtl/core/chrl_pkg.sv =====
// ----------------------------------------------------------------------------
// chrl_pkg
// Shared types and constants for the consistent-hash ring lookup block.
// ----------------------------------------------------------------------------
package chrl_pkg;

  localparam int RING_SIZE = 256;
  localparam int IDX_W     = $clog2(RING_SIZE);
  localparam int CNT_W     = $clog2(RING_SIZE + 1);
  localparam int GRP       = (RING_SIZE < 16) ? RING_SIZE : 16;
  localparam int NGRP      = (RING_SIZE + GRP - 1) / GRP;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_GRP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] hash_value;
    logic [7:0]  node_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] owner_node;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    kind_e       op;
    logic [31:0] hash;
    logic [7:0]  node;
  } cmd_t;

endpackage

// ===== rtl/core/consistent_hash_ring_lookup.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup
// Sorted ring of (point, owner) entries with insert, clear and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_data_i and push; an item is taken when full is low.
//   Result queue: one result per item, oldest first, shown while empty is
//   low and removed by pop.
//   Kinds: clear empties the ring; insert places a point in sorted order
//   (status full and dropped when the ring holds RING_SIZE entries); lookup
//   returns the owner of the first point >= key, wrapping to entry 0
//   (status empty on an empty ring).
//   Steps from accept to result, set by the back-end sequencer: clear,
//   error and unused kinds go straight to the result slot; insert compares,
//   then shifts; lookup compares, then runs the group search and the final
//   select. The back end handles one item at a time and takes no new item
//   until the result slot has been popped.
//   A two-entry command queue keeps the input side taking items while the
//   back end works or the receiver stalls; full rises once it fills.
//   Reset empties the ring and both queues; ring cells are not cleared.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  chrl_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output chrl_pkg::out_item_t out_data_o
);
  import chrl_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  chrl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  chrl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/chrl_front.sv =====
// ----------------------------------------------------------------------------
// chrl_front
// Accepts items, decodes the kind and queues commands for the back end.
// ----------------------------------------------------------------------------
module chrl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  chrl_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  output chrl_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);
  import chrl_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;
  cmd_t       cmd_new;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    cmd_new.op   = kind_e'(in_data_i.kind);
    cmd_new.hash = in_data_i.hash_value;
    cmd_new.node = in_data_i.node_id;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/chrl_back.sv =====
// ----------------------------------------------------------------------------
// chrl_back
// Ring cells, compare flags, insert shift, two-level search and result slot.
// ----------------------------------------------------------------------------
module chrl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  chrl_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output chrl_pkg::out_item_t out_data_o
);
  import chrl_pkg::*;

  state_e          state_q, state_d;
  logic [31:0]     pts_q  [RING_SIZE];
  logic [7:0]      owns_q [RING_SIZE];
  logic [CNT_W-1:0] count_q;
  logic [RING_SIZE-1:0] flag_d, flag_q;
  logic [31:0]     hash_q;
  logic [7:0]      node_q;
  logic [NGRP-1:0] ghit_d, ghit_q;
  logic [7:0]      gown_d [NGRP];
  logic [7:0]      gown_q [NGRP];
  logic [7:0]      fin_own;
  out_item_t       res_q, res_d;
  logic            res_v_q;
  logic            load, clr, cmp_en, shift_en, grp_en;

  // per-cell compare: lookup wants point >= key, insert wants point > new point
  always_comb begin
    for (int i = 0; i < RING_SIZE; i++) begin
      flag_d[i] = (CNT_W'(i) < count_q) &&
                  ((cmd_i.op == KIND_LOOKUP) ? (pts_q[i] >= cmd_i.hash)
                                             : (pts_q[i] > cmd_i.hash));
    end
  end

  // first hit inside each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      ghit_d[g] = 1'b0;
      gown_d[g] = 8'd0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if ((g * GRP + k) < RING_SIZE) begin
          if (flag_q[IDX_W'(g * GRP + k)]) begin
            ghit_d[g] = 1'b1;
            gown_d[g] = owns_q[IDX_W'(g * GRP + k)];
          end
        end
      end
    end
  end

  // first hit group; no hit wraps to entry 0
  always_comb begin
    fin_own = owns_q[0];
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (ghit_q[g]) fin_own = gown_q[g];
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    load      = 1'b0;
    res_d     = res_q;
    clr       = 1'b0;
    cmp_en    = 1'b0;
    shift_en  = 1'b0;
    grp_en    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_v_q) begin
          cmd_pop_o        = 1'b1;
          res_d.owner_node = 8'd0;
          res_d.status     = ST_OK;
          case (cmd_i.op)
            KIND_CLEAR: begin
              clr  = 1'b1;
              load = 1'b1;
            end
            KIND_INSERT: begin
              if (count_q == CNT_W'(RING_SIZE)) begin
                res_d.status = ST_FULL;
                load         = 1'b1;
              end else begin
                cmp_en  = 1'b1;
                state_d = S_SHIFT;
              end
            end
            KIND_LOOKUP: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                load         = 1'b1;
              end else begin
                cmp_en  = 1'b1;
                state_d = S_GRP;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      S_SHIFT: begin
        shift_en         = 1'b1;
        load             = 1'b1;
        res_d.owner_node = 8'd0;
        res_d.status     = ST_OK;
        state_d          = S_IDLE;
      end
      S_GRP: begin
        grp_en  = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        load             = 1'b1;
        res_d.owner_node = fin_own;
        res_d.status     = ST_OK;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) count_q <= '0;
      else if (shift_en) count_q <= count_q + CNT_W'(1);
      if (load) res_v_q <= 1'b1;
      else if (pop && res_v_q) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
    if (cmp_en) begin
      flag_q <= flag_d;
      hash_q <= cmd_i.hash;
      node_q <= cmd_i.node;
    end
    if (grp_en) begin
      ghit_q <= ghit_d;
      for (int g = 0; g < NGRP; g++) gown_q[g] <= gown_d[g];
    end
    // larger entries move up one cell, new entry lands in the gap
    if (shift_en) begin
      for (int i = 0; i < RING_SIZE; i++) begin
        if (i > 0 && flag_q[IDX_W'(i > 0 ? i - 1 : 0)]) begin
          pts_q[i]  <= pts_q[IDX_W'(i > 0 ? i - 1 : 0)];
          owns_q[i] <= owns_q[IDX_W'(i > 0 ? i - 1 : 0)];
        end else if (flag_q[i] || CNT_W'(i) == count_q) begin
          pts_q[i]  <= hash_q;
          owns_q[i] <= node_q;
        end
      end
    end
  end

  assign empty      = !res_v_q;
  assign out_data_o = res_q;

endmodule

// ===== rtl/core/chrl_checker.sv =====
// ----------------------------------------------------------------------------
// chrl_checker
// Port-level checks for the ring lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module chrl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input chrl_pkg::out_item_t out_data_o
);
  import chrl_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.status == ST_OK || out_data_o.status == ST_EMPTY ||
                out_data_o.status == ST_FULL))
    else $error("illegal status code");

  a_err_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.status != ST_OK) |-> out_data_o.owner_node == 8'd0)
    else $error("error result carries an owner");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result present right after reset");

endmodule

bind consistent_hash_ring_lookup chrl_checker u_chrl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);
